>>> hw/rtl/spi_mbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_mbs_pkg
// Types and constants shared by the spi master byte shifter modules.
// ----------------------------------------------------------------------------
package spi_mbs_pkg;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned HalfBits   = 16;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = HalfBits;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_CPOL              = 2'd0,
    CFG_CPHA              = 2'd1,
    CFG_HALF_PERIOD_TICKS = 2'd2,
    CFG_DELAY_ENABLE      = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_LOAD = 1'b1
  } mode_e;

  typedef struct packed {
    logic                cpol;
    logic                cpha;
    logic [HalfBits-1:0] half_period_ticks;
    logic                delay_enable;
  } cfg_t;

  typedef struct packed {
    logic                mode;
    logic [ByteBits-1:0] tx_byte;
    logic                end_of_transfer;
    logic                cipo_level;
  } req_t;

  typedef struct packed {
    logic                sck_level;
    logic                copi_level;
    logic [ByteBits-1:0] rx_byte;
    logic                rx_done;
    logic                busy_res;
  } res_t;

endpackage

>>> hw/rtl/spi_mbs_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_mbs_engine
// Bit timing and shift state; updates once per accepted request.
// ----------------------------------------------------------------------------
module spi_mbs_engine #(
  parameter int unsigned WORD_BITS        = 8,
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  spi_mbs_pkg::req_t   req_i,
  input  spi_mbs_pkg::cfg_t   cfg_i,
  output spi_mbs_pkg::res_t   res_o
);
  import spi_mbs_pkg::*;

  localparam int unsigned IdxBits = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(WORD_BITS - 1);

  logic [WORD_BITS-1:0]        send_q, send_d;
  logic [WORD_BITS-1:0]        recv_q, recv_d;
  logic [IdxBits-1:0]          bit_q, bit_d;
  logic                        second_q, second_d;
  logic [TICK_COUNT_WIDTH-1:0] tick_q, tick_d;
  logic                        active_q, active_d;
  logic                        last_q, last_d;
  logic                        sck_q, sck_d;
  logic                        copi_q, copi_d;

  logic [HalfBits-1:0]         half_raw;
  logic [TICK_COUNT_WIDTH-1:0] half_len;
  logic [TICK_COUNT_WIDTH-1:0] tick_inc;
  logic [WORD_BITS-1:0]        rx_word;
  logic                        done;

  always_comb begin
    half_raw = cfg_i.delay_enable ? cfg_i.half_period_ticks : HalfBits'(1);
    if (half_raw == '0) begin
      half_raw = HalfBits'(1);
    end
    half_len = TICK_COUNT_WIDTH'({{TICK_COUNT_WIDTH{1'b0}}, half_raw});
    if (half_len == '0) begin
      half_len = '1;
    end
  end

  assign tick_inc = tick_q + TICK_COUNT_WIDTH'(1);

  always_comb begin
    send_d   = send_q;
    recv_d   = recv_q;
    bit_d    = bit_q;
    second_d = second_q;
    tick_d   = tick_q;
    active_d = active_q;
    last_d   = last_q;
    sck_d    = sck_q;
    copi_d   = copi_q;
    done     = 1'b0;
    rx_word  = '0;
    if (accept_i) begin
      if (req_i.mode == MODE_LOAD) begin
        if (!active_q) begin
          send_d   = WORD_BITS'({{WORD_BITS{1'b0}}, req_i.tx_byte});
          recv_d   = '0;
          last_d   = req_i.end_of_transfer;
          active_d = 1'b1;
          bit_d    = '0;
          second_d = 1'b0;
          tick_d   = '0;
          sck_d    = cfg_i.cpol;
        end
      end else if (active_q) begin
        tick_d = tick_inc;
        if (tick_inc >= half_len) begin
          tick_d = '0;
          if (!second_q) begin
            if (cfg_i.cpha) begin
              recv_d = {recv_q[WORD_BITS-2:0], req_i.cipo_level};
            end else begin
              copi_d = send_q[WORD_BITS-1];
              send_d = {send_q[WORD_BITS-2:0], 1'b0};
            end
            sck_d    = ~cfg_i.cpol;
            second_d = 1'b1;
          end else begin
            if (cfg_i.cpha) begin
              copi_d = send_q[WORD_BITS-1];
              send_d = {send_q[WORD_BITS-2:0], 1'b0};
            end else begin
              recv_d = {recv_q[WORD_BITS-2:0], req_i.cipo_level};
            end
            second_d = 1'b0;
            if (bit_q == LastIdx) begin
              bit_d    = '0;
              done     = 1'b1;
              rx_word  = recv_d;
              active_d = 1'b0;
              if (last_q) begin
                sck_d  = cfg_i.cpol;
                copi_d = 1'b0;
                last_d = 1'b0;
              end
            end else begin
              bit_d = bit_q + IdxBits'(1);
              sck_d = cfg_i.cpol;
            end
          end
        end
      end
    end
  end

  always_comb begin
    res_o.sck_level  = sck_d;
    res_o.copi_level = copi_d;
    res_o.rx_byte    = ByteBits'({{ByteBits{1'b0}}, rx_word});
    res_o.rx_done    = done;
    res_o.busy_res   = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_q   <= '0;
      recv_q   <= '0;
      bit_q    <= '0;
      second_q <= 1'b0;
      tick_q   <= '0;
      active_q <= 1'b0;
      last_q   <= 1'b0;
      sck_q    <= 1'b0;
      copi_q   <= 1'b0;
    end else begin
      send_q   <= send_d;
      recv_q   <= recv_d;
      bit_q    <= bit_d;
      second_q <= second_d;
      tick_q   <= tick_d;
      active_q <= active_d;
      last_q   <= last_d;
      sck_q    <= sck_d;
      copi_q   <= copi_d;
    end
  end

endmodule

>>> hw/rtl/spi_master_byte_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_byte_shifter
// SPI master that shifts one word MSB first, paced by tick requests.
// ----------------------------------------------------------------------------
// usage:
//   in channel  (in_valid_i / in_stall_o / in_data_i): one request per tick of
//     the serial timing base, or a load of the word to send
//   out channel (out_valid_o / out_stall_i / out_data_o): one result per
//     request with the line levels, received byte, done flag and busy flag
//   config port (cfg_we_i / cfg_idx_i / cfg_data_i): polarity, phase, half
//     period in ticks and delay enable; write only while idle
// result: registered, valid in the cycle after the request is accepted
// throughput: one request per cycle while in_stall_o is low, since the
//   combinational state update feeds the output register
// reset: shifter idle, sck and copi low, config at its defaults
// stall: while a result waits in the output register and the receiver
//   stalls, in_stall_o is raised and the shifter state holds
// ----------------------------------------------------------------------------
module spi_master_byte_shifter #(
  parameter int unsigned WORD_BITS        = 8,
  parameter int unsigned TICK_COUNT_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  spi_mbs_pkg::req_t                      in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output spi_mbs_pkg::res_t                      out_data_o,
  input  logic                                   cfg_we_i,
  input  logic [spi_mbs_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [spi_mbs_pkg::CfgDataBits-1:0]    cfg_data_i
);
  import spi_mbs_pkg::*;

  cfg_t cfg_q;
  res_t res;
  res_t out_q;
  logic out_valid_q;
  logic accept;

  // output register frees up when empty or being taken
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cpol              <= 1'b0;
      cfg_q.cpha              <= 1'b0;
      cfg_q.half_period_ticks <= HalfBits'(1);
      cfg_q.delay_enable      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CPOL:              cfg_q.cpol              <= cfg_data_i[0];
        CFG_CPHA:              cfg_q.cpha              <= cfg_data_i[0];
        CFG_HALF_PERIOD_TICKS: cfg_q.half_period_ticks <= cfg_data_i[HalfBits-1:0];
        CFG_DELAY_ENABLE:      cfg_q.delay_enable      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  spi_mbs_engine #(
    .WORD_BITS       (WORD_BITS),
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .req_i   (in_data_i),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  a_done_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.rx_done) |-> !out_data_o.busy_res)
    else $error("word finished while still busy");

  a_rx_zero_unless_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.rx_done) |-> (out_data_o.rx_byte == '0))
    else $error("received byte shown without done");

  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted request produced no result");
`endif

endmodule

>>> tb/sv/spi_master_byte_shifter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_byte_shifter_test
// Self-checking bench for the SPI master byte shifter. A short table of
// directed requests and register writes is walked first, then random phases
// of load and tick requests run under several mode, half-period and delay
// settings. Directed rows may give a typed result; a behavioral model of the
// shifter predicts the rest, and all are checked field by field in arrival
// order with random gaps, stalls on both channels and one long receiver hold.
// ----------------------------------------------------------------------------
module spi_master_byte_shifter_test;
  import spi_mbs_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LongHoldCycles = 200;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems = 180;

  typedef enum logic {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [7:0]         count;
    req_t               req;
    cfg_idx_e           cfg_idx;
    logic [CfgDataBits-1:0] cfg_data;
    logic               has_res;
    res_t               typed_res;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  req_t                   in_data_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  res_t                   out_data_o;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;

  // shifter model state
  logic             cfg_pol;
  logic             cfg_pha;
  logic [15:0]      cfg_half;
  logic             cfg_delay;
  logic [7:0]       tx_shreg;
  logic [7:0]       rx_shreg;
  int unsigned      bit_cnt;
  logic             in_second_half;
  logic [15:0]      tick_cnt;
  logic             shifting;
  logic             last_word;
  logic             sck_q;
  logic             copi_q;

  res_t             expected_levels[$];
  int unsigned      mismatches = 0;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;
  int unsigned      long_hold_reqs = 0;
  int unsigned      long_hold_seen = 0;
  int unsigned      hold_left = 0;
  int unsigned      quiet_cycles = 0;
  dir_row_t         dir_rows [14];

  spi_master_byte_shifter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic shifter_reset();
    cfg_pol = 1'b0;
    cfg_pha = 1'b0;
    cfg_half = 16'd1;
    cfg_delay = 1'b1;
    tx_shreg = '0;
    rx_shreg = '0;
    bit_cnt = 0;
    in_second_half = 1'b0;
    tick_cnt = '0;
    shifting = 1'b0;
    last_word = 1'b0;
    sck_q = 1'b0;
    copi_q = 1'b0;
  endtask

  task automatic shifter_step(input req_t r, output res_t res);
    int unsigned len;
    logic        done;
    logic [7:0]  rx_out;
    done = 1'b0;
    rx_out = '0;
    if (r.mode == MODE_LOAD) begin
      if (!shifting) begin
        tx_shreg = r.tx_byte;
        rx_shreg = '0;
        last_word = r.end_of_transfer;
        shifting = 1'b1;
        bit_cnt = 0;
        in_second_half = 1'b0;
        tick_cnt = '0;
        sck_q = cfg_pol;
      end
    end else if (shifting) begin
      len = cfg_delay ? int'(cfg_half) : 1;
      if (len == 0) len = 1;
      tick_cnt = tick_cnt + 16'd1;
      if (int'(tick_cnt) >= len) begin
        tick_cnt = '0;
        if (!in_second_half) begin
          if (cfg_pha) begin
            rx_shreg = {rx_shreg[6:0], r.cipo_level};
          end else begin
            copi_q = tx_shreg[7];
            tx_shreg = tx_shreg << 1;
          end
          sck_q = ~cfg_pol;
          in_second_half = 1'b1;
        end else begin
          if (cfg_pha) begin
            copi_q = tx_shreg[7];
            tx_shreg = tx_shreg << 1;
          end else begin
            rx_shreg = {rx_shreg[6:0], r.cipo_level};
          end
          in_second_half = 1'b0;
          bit_cnt++;
          if (bit_cnt >= 8) begin
            bit_cnt = 0;
            done = 1'b1;
            rx_out = rx_shreg;
            shifting = 1'b0;
            if (last_word) begin
              sck_q = cfg_pol;
              copi_q = 1'b0;
              last_word = 1'b0;
            end
          end else begin
            sck_q = cfg_pol;
          end
        end
      end
    end
    res.sck_level = sck_q;
    res.copi_level = copi_q;
    res.rx_byte = rx_out;
    res.rx_done = done;
    res.busy_res = shifting;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("mismatch %s at %0t ns: got %0h, expected %0h", what, $time, got, want);
  endtask

  task automatic send_request(input req_t r, input logic use_typed, input res_t typed);
    res_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    shifter_step(r, predicted);
    expected_levels.push_back(use_typed ? typed : predicted);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_CPOL:              cfg_pol = data[0];
      CFG_CPHA:              cfg_pha = data[0];
      CFG_HALF_PERIOD_TICKS: cfg_half = data;
      CFG_DELAY_ENABLE:      cfg_delay = data[0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_phase(input logic pol, input logic pha, input logic [15:0] half,
                             input logic delay, input int unsigned tx_pct,
                             input int unsigned rx_pct);
    wait_results_drained();
    write_reg(CFG_CPOL, {15'($urandom), pol});
    write_reg(CFG_CPHA, {15'($urandom), pha});
    write_reg(CFG_HALF_PERIOD_TICKS, half);
    write_reg(CFG_DELAY_ENABLE, {15'($urandom), delay});
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  task automatic run_random_phase(input int unsigned target);
    int unsigned counted;
    req_t        r;
    counted = 0;
    while (counted < target) begin
      r.cipo_level = 1'($urandom);
      r.tx_byte = 8'($urandom);
      r.end_of_transfer = 1'($urandom);
      if (!shifting) r.mode = ($urandom_range(0, 99) < 85) ? MODE_LOAD : MODE_TICK;
      else r.mode = ($urandom_range(0, 99) < 8) ? MODE_LOAD : MODE_TICK;
      counted++;
      send_request(r, 1'b0, '0);
    end
    // finish the byte in flight
    while (shifting) begin
      r.mode = MODE_TICK;
      r.cipo_level = 1'($urandom);
      send_request(r, 1'b0, '0);
    end
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    if (long_hold_reqs != long_hold_seen) begin
      long_hold_seen = long_hold_reqs;
      hold_left = LongHoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("result with no request pending", out_data_o.rx_byte, 8'h00);
      end else begin
        want = expected_levels.pop_front();
        if (out_data_o.sck_level !== want.sck_level)
          report_mismatch("sck_level", 8'(out_data_o.sck_level), 8'(want.sck_level));
        if (out_data_o.copi_level !== want.copi_level)
          report_mismatch("copi_level", 8'(out_data_o.copi_level), 8'(want.copi_level));
        if (out_data_o.rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", out_data_o.rx_byte, want.rx_byte);
        if (out_data_o.rx_done !== want.rx_done)
          report_mismatch("rx_done", 8'(out_data_o.rx_done), 8'(want.rx_done));
        if (out_data_o.busy_res !== want.busy_res)
          report_mismatch("busy_res", 8'(out_data_o.busy_res), 8'(want.busy_res));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)
          || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    shifter_reset();
    dir_rows = '{
      // tick while idle
      '{ROW_REQ, 8'd1, '{MODE_TICK, 8'hFF, 1'b1, 1'b1}, CFG_CPOL, 16'h0000,
        1'b1, '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
      '{ROW_REQ, 8'd1, '{MODE_LOAD, 8'hFF, 1'b0, 1'b0}, CFG_CPOL, 16'h0000,
        1'b1, '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1}},
      // load while busy is dropped
      '{ROW_REQ, 8'd1, '{MODE_LOAD, 8'h00, 1'b1, 1'b1}, CFG_CPOL, 16'h0000,
        1'b1, '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1}},
      '{ROW_REQ, 8'd8, '{MODE_TICK, 8'h00, 1'b0, 1'b1}, CFG_CPOL, 16'h0000,
        1'b0, '0},
      // zero half period, written mid-byte
      '{ROW_CFG, 8'd0, '0, CFG_HALF_PERIOD_TICKS, 16'h0000, 1'b0, '0},
      '{ROW_REQ, 8'd8, '{MODE_TICK, 8'h00, 1'b0, 1'b1}, CFG_CPOL, 16'h0000,
        1'b0, '0},
      // between words sck holds
      '{ROW_REQ, 8'd1, '{MODE_TICK, 8'h00, 1'b0, 1'b0}, CFG_CPOL, 16'h0000,
        1'b0, '0},
      '{ROW_CFG, 8'd0, '0, CFG_CPOL, 16'hFFFF, 1'b0, '0},
      '{ROW_CFG, 8'd0, '0, CFG_CPHA, 16'h0001, 1'b0, '0},
      '{ROW_CFG, 8'd0, '0, CFG_HALF_PERIOD_TICKS, 16'hFFFF, 1'b0, '0},
      '{ROW_CFG, 8'd0, '0, CFG_DELAY_ENABLE, 16'hFFFE, 1'b0, '0},
      '{ROW_REQ, 8'd1, '{MODE_LOAD, 8'h00, 1'b1, 1'b0}, CFG_CPOL, 16'h0000,
        1'b0, '0},
      '{ROW_REQ, 8'd16, '{MODE_TICK, 8'hFF, 1'b0, 1'b0}, CFG_CPOL, 16'h0000,
        1'b0, '0},
      // end of transfer: sck back to polarity, copi low
      '{ROW_REQ, 8'd1, '{MODE_TICK, 8'h00, 1'b0, 1'b1}, CFG_CPOL, 16'h0000,
        1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0}}
    };
    tx_idle_pct = 34;
    rx_idle_pct = 68;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_results_drained();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_data);
      end else begin
        for (int n = 0; n < dir_rows[i].count; n++)
          send_request(dir_rows[i].req, dir_rows[i].has_res, dir_rows[i].typed_res);
      end
    end

    apply_phase(1'b0, 1'b0, 16'd1, 1'b1, 34, 68);
    run_random_phase(PhaseItems);
    apply_phase(1'b1, 1'b0, 16'd3, 1'b1, 34, 68);
    run_random_phase(PhaseItems);
    apply_phase(1'b0, 1'b1, 16'd0, 1'b1, 68, 34);
    run_random_phase(PhaseItems);
    apply_phase(1'b1, 1'b1, 16'hFFFF, 1'b0, 68, 34);
    run_random_phase(PhaseItems);
    apply_phase(1'($urandom), 1'($urandom), 16'($urandom_range(1, 4)), 1'b1, 0, 0);
    long_hold_reqs++;
    run_random_phase(PhaseItems);
    apply_phase(1'($urandom), 1'($urandom), 16'($urandom_range(1, 6)), 1'($urandom),
                0, 0);
    run_random_phase(PhaseItems);

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/spi_mbs_pkg.sv
hw/rtl/spi_mbs_engine.sv
hw/rtl/spi_master_byte_shifter.sv
tb/sv/spi_master_byte_shifter_test.sv
